@@ hdl/preemptive_priority_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Clocked, reset-qualified property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and width helpers shared by the scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

   localparam int NUM_PROCS = 16;
   localparam int TIME_BITS = 16;
   localparam int IDX_BITS  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int TICK_BITS = 20;
   localparam int CNT_BITS  = 5;
   localparam int CMP_BITS  = (IDX_BITS + 1 > CNT_BITS) ? IDX_BITS + 1 : CNT_BITS;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  entry_index;
      logic [7:0]  priority_value;
      logic [15:0] run_time;
   } req_type;

   typedef struct packed {
      logic [3:0]  chosen_index;
      logic [15:0] time_left;
      logic        completed;
      logic [19:0] finish_tick;
      logic        all_done;
   } rsp_type;

   // best candidate so far, passed from cell to cell
   typedef struct packed {
      logic                 found;
      logic [7:0]           prio;
      logic [IDX_BITS-1:0]  index;
      logic [TIME_BITS-1:0] remain;
   } tok_type;

   // write broadcast to the cells
   typedef struct packed {
      logic                 wr_en;
      logic [IDX_BITS-1:0]  wr_index;
      logic                 prio_en;
      logic [7:0]           prio;
      logic [TIME_BITS-1:0] remain;
      logic                 fin_en;
      logic [TICK_BITS-1:0] finish;
   } cell_wr_type;

   function automatic logic [3:0] idx_to_field(logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS+3:0] wide;
      wide = {4'd0, idx};
      return wide[3:0];
   endfunction

   function automatic logic [IDX_BITS-1:0] field_to_idx(logic [3:0] fld);
      logic [IDX_BITS+3:0] wide;
      wide = {{IDX_BITS{1'b0}}, fld};
      return wide[IDX_BITS-1:0];
   endfunction

   function automatic logic idx_in_range(logic [3:0] fld);
      return int'(fld) < NUM_PROCS;
   endfunction

   function automatic logic [15:0] time_to_field(logic [TIME_BITS-1:0] t);
      logic [TIME_BITS+15:0] wide;
      wide = {16'd0, t};
      return wide[15:0];
   endfunction

   function automatic logic [TIME_BITS-1:0] field_to_time(logic [15:0] fld);
      logic [TIME_BITS+15:0] wide;
      wide = {{TIME_BITS{1'b0}}, fld};
      return wide[TIME_BITS-1:0];
   endfunction

endpackage

@@ hdl/pps_cell.sv @@
// ----------------------------------------------------------------------------
// pps_cell
// One table entry: priority, remaining time and finish time, plus one stage
// of the minimum-priority search that runs down the row of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pps_pkg::IDX_BITS-1:0]  cell_index,
   input  logic [pps_pkg::CNT_BITS-1:0]  proc_count,
   input  pps_pkg::cell_wr_type          wr,
   input  pps_pkg::tok_type              tok_in,
   output pps_pkg::tok_type              tok_out,
   output logic [pps_pkg::TICK_BITS-1:0] finish_out
);
   import pps_pkg::*;

   logic [7:0]           prio_ff;
   logic [TIME_BITS-1:0] remain_ff;
   logic [TICK_BITS-1:0] finish_ff;
   tok_type              tok_ff;
   tok_type              tok_in_w;
   logic                 hit;
   logic                 active;
   logic                 take;

   assign hit    = wr.wr_en && (wr.wr_index == cell_index);
   assign active = (CMP_BITS'(cell_index) < CMP_BITS'(proc_count)) && (remain_ff != '0);
   // strict compare keeps the lower index on a tie
   assign take   = active && (!tok_in.found || (prio_ff < tok_in.prio));

   always_comb begin
      tok_in_w = tok_in;
      if (take) begin
         tok_in_w.found  = 1'b1;
         tok_in_w.prio   = prio_ff;
         tok_in_w.index  = cell_index;
         tok_in_w.remain = remain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         remain_ff <= wr.remain;
         if (wr.prio_en) begin
            prio_ff <= wr.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finish_ff <= '0;
      end else if (hit && wr.fin_en) begin
         finish_ff <= wr.finish;
      end
   end

   // advance the search one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out    = tok_ff;
   assign finish_out = finish_ff;

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Static-priority scheduler over a row of process cells. Load and read items
// are handled straight from the idle state; a tick item runs the search for
// the smallest priority, which walks down the row of cells one entry per
// cycle before the chosen entry is updated. While a tick is in progress no
// new item is taken. A result waiting on a stalled output holds the block
// until it is taken. Reset clears finish times and the tick counter; load
// every entry in use before the first tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pps_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);
   import pps_pkg::*;

   `include "preemptive_priority_scheduler_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [IDX_BITS-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [CNT_BITS-1:0]  proc_count_ff;
   rsp_type              hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   tok_type              tok_w [NUM_PROCS+1];
   logic [TICK_BITS-1:0] finish_arr [NUM_PROCS];
   cell_wr_type          wr;
   rsp_type              res;
   logic                 res_en;
   logic                 out_free;
   logic [TIME_BITS-1:0] new_rem;
   logic [TICK_BITS-1:0] tick_next;
   logic [IDX_BITS-1:0]  rd_sel;
   tok_type              last_tok;

   assign tok_w[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_PROCS; gi++) begin : g_cell
         pps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_BITS'(gi)),
            .proc_count (proc_count_ff),
            .wr         (wr),
            .tok_in     (tok_w[gi]),
            .tok_out    (tok_w[gi+1]),
            .finish_out (finish_arr[gi])
         );
      end
   endgenerate

   assign last_tok  = tok_w[NUM_PROCS];
   assign new_rem   = last_tok.remain - TIME_BITS'(1);
   assign tick_next = tick_ff + TICK_BITS'(1);
   assign rd_sel    = field_to_idx(req_data.entry_index);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      tick_in      = tick_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;
      res          = '0;
      res_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.command)
                  CMD_LOAD: begin
                     if (idx_in_range(req_data.entry_index)) begin
                        wr.wr_en    = 1'b1;
                        wr.wr_index = rd_sel;
                        wr.prio_en  = 1'b1;
                        wr.prio     = req_data.priority_value;
                        wr.remain   = field_to_time(req_data.run_time);
                        wr.fin_en   = 1'b1;
                        wr.finish   = '0;
                     end
                  end
                  CMD_TICK: begin
                     state_in    = ST_SCAN;
                     scan_cnt_in = '0;
                  end
                  CMD_READ: begin
                     res.chosen_index = req_data.entry_index;
                     res.finish_tick  = idx_in_range(req_data.entry_index) ?
                                        finish_arr[rd_sel] : '0;
                     res_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == IDX_BITS'(NUM_PROCS - 1)) begin
               state_in = ST_IDLE;
               res_en   = 1'b1;
               if (last_tok.found) begin
                  wr.wr_en         = 1'b1;
                  wr.wr_index      = last_tok.index;
                  wr.remain        = new_rem;
                  wr.fin_en        = (new_rem == '0);
                  wr.finish        = tick_next;
                  tick_in          = tick_next;
                  res.chosen_index = idx_to_field(last_tok.index);
                  res.time_left    = time_to_field(new_rem);
                  res.completed    = (new_rem == '0);
                  res.finish_tick  = (new_rem == '0) ? tick_next : '0;
               end else begin
                  res.all_done = 1'b1;
               end
            end else begin
               scan_cnt_in = scan_cnt_ff + IDX_BITS'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_data_in  = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // park the result when the output register is still occupied
      if (res_en) begin
         if (out_free) begin
            rsp_data_in  = res;
            rsp_valid_in = 1'b1;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_cnt_ff   <= '0;
         tick_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         proc_count_ff <= CNT_BITS'(1);
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            proc_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PPS_ASSERT_NEXT(a_tick_starts_scan,
      req_valid && !req_stall && (req_data.command == CMD_TICK),
      (state_ff == ST_SCAN) && (scan_cnt_ff == '0), "tick item did not start a scan")
   `PPS_ASSERT_NEXT(a_counter_quiet_in_scan,
      (state_ff == ST_SCAN) && (scan_cnt_ff != IDX_BITS'(NUM_PROCS - 1)),
      $stable(tick_ff), "tick counter moved during a scan")
   `PPS_ASSERT_NOW(a_hold_needs_busy_output, state_ff == ST_HOLD, rsp_valid_ff,
      "result parked while output register is empty")
   `PPS_ASSERT_NEXT(a_stalled_result_kept, rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable(rsp_data_ff), "stalled result was overwritten")

endmodule
